@@ hw/rtl/min_tracking_stack_defines.svh @@
// Assertion helpers for the stack RTL, included by mts_ctrl.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define MTS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a trigger is followed in the next cycle by a condition.
`define MTS_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

@@ hw/rtl/mts_pkg.sv @@
`default_nettype none

package mts_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;
   localparam int DATA_W = 32;
   localparam int DEPTH_W = 5;
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;

   localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // One stack level: the value and the minimum of it and everything below.
   typedef struct packed {
      logic signed [DATA_W-1:0] min_v;
      logic signed [DATA_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic                     valid;
      logic [STATUS_W-1:0]      status;
      logic [DEPTH_W-1:0]       depth;
      logic signed [DATA_W-1:0] min_v;
      logic signed [DATA_W-1:0] top_v;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/mts_stack_ram.sv @@
`default_nettype none

module mts_stack_ram #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH,
   localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  wire                     clock,
   input  mts_pkg::mem_ctl_type    mem_ctl,
   input  wire  [AddrW-1:0]        wr_addr,
   input  mts_pkg::entry_type      wr_data,
   input  wire  [AddrW-1:0]        rd_addr,
   output mts_pkg::entry_type      rd_data
);

   mts_pkg::entry_type mem_ff [STACK_DEPTH];
   mts_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mts_ctrl.sv @@
`default_nettype none

`include "min_tracking_stack_defines.svh"

module mts_ctrl #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH,
   localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   localparam int CountW = $clog2(STACK_DEPTH + 1)
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [mts_pkg::OPCODE_W-1:0]       opcode,
   input  wire  signed [mts_pkg::DATA_W-1:0]  push_value,
   input  wire                                slot_free,
   output mts_pkg::result_type                result,
   output mts_pkg::mem_ctl_type               mem_ctl,
   output logic [AddrW-1:0]                   wr_addr,
   output mts_pkg::entry_type                 wr_data,
   output logic [AddrW-1:0]                   rd_addr,
   input  mts_pkg::entry_type                 rd_data
);

   typedef enum logic {
      ST_IDLE,
      ST_POP_WAIT
   } state_type;

   state_type                       state_ff, state_in;
   logic [CountW-1:0]               count_ff, count_in;
   logic signed [mts_pkg::DATA_W-1:0] top_val_ff, top_val_in;
   logic signed [mts_pkg::DATA_W-1:0] top_min_ff, top_min_in;

   logic                            accept;
   logic                            full;
   logic [CountW-1:0]               count_m1;
   logic [CountW-1:0]               count_m2;
   logic signed [mts_pkg::DATA_W-1:0] new_min;

   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff >= CountW'(STACK_DEPTH);
   assign count_m1  = count_ff - CountW'(1);
   assign count_m2  = count_ff - CountW'(2);

   // The first push onto an empty stack takes its own value as the minimum.
   assign new_min = ((count_ff != '0) && (top_min_ff < push_value)) ? top_min_ff : push_value;

   assign wr_addr = count_ff[AddrW-1:0];
   assign rd_addr = count_m2[AddrW-1:0];
   assign wr_data = '{min_v: new_min, value: push_value};

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      top_val_in     = top_val_ff;
      top_min_in     = top_min_ff;
      mem_ctl        = '0;
      result         = '0;
      result.status  = mts_pkg::STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               result.valid = 1'b1;
               result.depth = mts_pkg::DEPTH_W'(count_ff);
               if (count_ff != '0) begin
                  result.top_v = top_val_ff;
                  result.min_v = top_min_ff;
               end
               case (opcode)
                  mts_pkg::OP_PUSH: begin
                     if (full) begin
                        result.status = mts_pkg::STATUS_OVERFLOW;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        count_in      = count_ff + CountW'(1);
                        top_val_in    = push_value;
                        top_min_in    = new_min;
                        result.top_v  = push_value;
                        result.min_v  = new_min;
                        result.depth  = mts_pkg::DEPTH_W'(count_in);
                     end
                  end
                  mts_pkg::OP_POP: begin
                     result.top_v = '0;
                     result.min_v = '0;
                     if (count_ff == '0) begin
                        result.status = mts_pkg::STATUS_UNDERFLOW;
                     end else begin
                        count_in     = count_m1;
                        result.depth = mts_pkg::DEPTH_W'(count_m1);
                        // The new top lives in memory; its result waits for the read.
                        if (count_m1 != '0) begin
                           mem_ctl.rd_en = 1'b1;
                           result.valid  = 1'b0;
                           state_in      = ST_POP_WAIT;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            top_val_in    = rd_data.value;
            top_min_in    = rd_data.min_v;
            result.valid  = 1'b1;
            result.top_v  = rd_data.value;
            result.min_v  = rd_data.min_v;
            result.depth  = mts_pkg::DEPTH_W'(count_ff);
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
   end

   `MTS_ASSERT_ALWAYS(a_count_bound, count_ff <= CountW'(STACK_DEPTH), "stack count beyond depth")
   `MTS_ASSERT_ALWAYS(a_write_room, !mem_ctl.wr_en || !full, "write into a full stack")
   `MTS_ASSERT_NEXT(a_read_waits, mem_ctl.rd_en, state_ff == ST_POP_WAIT && count_ff != '0, "pop read without wait state")
   `MTS_ASSERT_ALWAYS(a_result_source, !result.valid || accept || state_ff == ST_POP_WAIT, "result without transaction")

endmodule

`default_nettype wire

@@ hw/rtl/min_tracking_stack.sv @@
// Bounded LIFO stack of signed 32-bit values that also tracks the minimum
// of everything it holds.
// The req channel carries one operation per transaction: req_tuser holds the
// opcode (push, pop, read only; the unused code reads), req_tdata the value
// to push. The rsp channel returns exactly one transaction per request with
// the top value, the minimum (both zero when empty), the depth and a status
// of ok, overflow (push onto a full stack) or underflow (pop when empty).
// Push and read results are registered and appear in the cycle after the
// request. A pop that leaves a non-empty stack reads the new top from the
// stack memory through its registered read port and then the output
// register. Push and read requests are taken one per cycle while the
// receiver keeps up; such a pop holds off the next request while it waits.
// A single output register holds the result; a new request is taken while
// it is being drained. When the receiver stalls, the result holds and
// req_tready stays low until the register frees up.
// Reset empties the stack at once; memory contents are not cleared.
`default_nettype none

module min_tracking_stack #(
   parameter int STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH,
   localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] push_value
   input  wire  [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] top_value, [63:32] min_value,
                                    // [68:64] depth_now, [71:69] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   mts_pkg::result_type   result;
   mts_pkg::result_type   rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  slot_free;
   mts_pkg::mem_ctl_type  mem_ctl;
   logic [AddrW-1:0]      wr_addr;
   logic [AddrW-1:0]      rd_addr;
   mts_pkg::entry_type    wr_data;
   mts_pkg::entry_type    rd_data;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   mts_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .opcode     (req_tuser),
      .push_value (req_tdata),
      .slot_free  (slot_free),
      .result     (result),
      .mem_ctl    (mem_ctl),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   mts_stack_ram #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.depth, rsp_ff.min_v, rsp_ff.top_v};
   assign rsp_tuser  = rsp_ff.status;

endmodule

`default_nettype wire
